// ----- hdl/ssf_pkg.sv -----
// Shared constants for the source component finder.
// No dependencies.
package ssf_pkg;
   localparam int MAX_VERTICES_DEFAULT = 64;
   localparam int ROW_W = 64;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_START = 1'b1;
endpackage

// ----- hdl/ssf_if.sv -----
// Valid/ready channel interfaces for request, response and register write.
// Uses ssf_pkg widths.
interface ssf_req_if import ssf_pkg::*; ();
   logic valid;
   logic ready;
   logic op;
   logic [IDX_W-1:0] row_index;
   logic [ROW_W-1:0] row_bits;
   modport source (output valid, op, row_index, row_bits, input ready);
   modport sink (input valid, op, row_index, row_bits, output ready);
endinterface

interface ssf_rsp_if import ssf_pkg::*; ();
   logic valid;
   logic ready;
   logic [ROW_W-1:0] component_mask;
   logic [IDX_W-1:0] source_vertex;
   modport source (output valid, component_mask, source_vertex, input ready);
   modport sink (input valid, component_mask, source_vertex, output ready);
endinterface

interface ssf_csr_if import ssf_pkg::*; ();
   logic valid;
   logic ready;
   logic [CNT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- hdl/ssf_rows.sv -----
// Adjacency memories: successor rows and predecessor rows, registered reads.
// Depends on ssf_pkg.
module ssf_rows import ssf_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  logic             clock,
   input  logic             succ_we,
   input  logic [IDX_W-1:0] succ_addr,
   input  logic [ROW_W-1:0] wr_succ,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [ROW_W-1:0] wr_pred,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [ROW_W-1:0] rd_succ,
   output logic [ROW_W-1:0] rd_pred
);
   logic [ROW_W-1:0] succ_mem [MAX_VERTICES];
   logic [ROW_W-1:0] pred_mem [MAX_VERTICES];

   // separate write ports per memory, shared read address, registered read data
   always_ff @(posedge clock) begin
      if (succ_we) succ_mem[succ_addr] <= wr_succ;
      if (wr_en) pred_mem[wr_addr] <= wr_pred;
      rd_succ <= succ_mem[rd_addr];
      rd_pred <= pred_mem[rd_addr];
   end
endmodule

// ----- hdl/source_scc_finder_unit.sv -----
// Source component finder top level: sequencer, stack and row memories.
// Depends on ssf_pkg, the ssf interfaces and ssf_rows.
//
// Row loads write the successor row in the accepting cycle and then rewrite
// the predecessor memory column-wise: a load walks all MAX_VERTICES
// predecessor rows with a read-modify-write, a read state and then a write
// state per row, and no new item is accepted until the walk is done.
// After reset a clearing pass zeroes the predecessor rows before items are
// taken. A search runs depth-first walks with a stack; each step is a stack
// read, a row read and one decision, and every reached vertex costs at most
// one push step and one pop step per pass. The forward scan tries each root
// candidate in turn. Results wait in an output register; new items are
// still taken while a result waits, and a later search holds in its output
// state until the register is free.
module source_scc_finder_unit import ssf_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input logic clock,
   input logic reset,
   ssf_req_if.sink   req,
   ssf_rsp_if.source rsp,
   ssf_csr_if.sink   csr
);
   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_LREAD = 4'd2,
      S_LWRITE = 4'd3, S_ROOT = 4'd4, S_RD = 4'd5, S_WAIT = 4'd6,
      S_STEP = 4'd7, S_BSTART = 4'd8, S_OUT = 4'd9;
   localparam logic [CNT_W-1:0] MAXV = CNT_W'(MAX_VERTICES);

   logic [3:0] state_ff, state_in;
   logic [CNT_W-1:0] vcount_ff, vcount_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;        // row or root counter
   logic [IDX_W-1:0] lrow_ff, lrow_in;
   logic [ROW_W-1:0] lbits_ff, lbits_in;
   logic [ROW_W-1:0] visited_ff, visited_in;
   logic [ROW_W-1:0] mask_ff, mask_in;
   logic back_ff, back_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [IDX_W-1:0] root_ff, root_in;
   logic rvalid_ff, rvalid_in;
   logic [ROW_W-1:0] rmask_ff, rmask_in;
   logic [IDX_W-1:0] rroot_ff, rroot_in;
   logic [IDX_W-1:0] stack_mem [MAX_VERTICES];
   logic [IDX_W-1:0] top_ff;
   logic st_we;
   logic [IDX_W-1:0] st_waddr, st_wdata, st_raddr;

   logic succ_we;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [ROW_W-1:0] wr_pred, rd_succ, rd_pred, row, nxt;
   logic [CNT_W-1:0] live;
   logic [ROW_W-1:0] all;
   logic [IDX_W-1:0] low;

   ssf_rows #(.MAX_VERTICES(MAX_VERTICES)) u_rows (
      .clock(clock), .succ_we(succ_we), .succ_addr(req.row_index),
      .wr_succ(req.row_bits), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_pred(wr_pred), .rd_addr(rd_addr), .rd_succ(rd_succ), .rd_pred(rd_pred)
   );

   // stack memory, read data registered
   always_ff @(posedge clock) begin
      if (st_we) stack_mem[st_waddr] <= st_wdata;
      top_ff <= stack_mem[st_raddr];
   end

   // clamped vertex count and its mask
   always_comb begin
      live = vcount_ff;
      if (live == '0) live = CNT_W'(1);
      if (live > MAXV) live = MAXV;
      all = (live >= CNT_W'(ROW_W)) ? '1 : ((ROW_W'(1) << live) - ROW_W'(1));
   end

   assign row = back_ff ? rd_pred : rd_succ;
   assign nxt = row & mask_ff & ~visited_ff;
   always_comb begin
      low = IDX_W'(ROW_W - 1);
      for (int k = ROW_W - 1; k >= 0; k--) if (nxt[k]) low = IDX_W'(k);
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rvalid_ff;
   assign rsp.component_mask = rmask_ff;
   assign rsp.source_vertex = rroot_ff;

   // sequencer
   always_comb begin
      state_in = state_ff; vcount_in = vcount_ff; cnt_in = cnt_ff;
      lrow_in = lrow_ff; lbits_in = lbits_ff; visited_in = visited_ff;
      mask_in = mask_ff; back_in = back_ff; depth_in = depth_ff;
      root_in = root_ff; rvalid_in = rvalid_ff; rmask_in = rmask_ff;
      rroot_in = rroot_ff;
      succ_we = 1'b0;
      wr_en = 1'b0; wr_addr = cnt_ff[IDX_W-1:0]; wr_pred = '0;
      rd_addr = cnt_ff[IDX_W-1:0];
      st_we = 1'b0; st_waddr = '0; st_wdata = '0;
      st_raddr = IDX_W'(depth_ff - CNT_W'(1));
      if (csr.valid) vcount_in = csr.data;
      if (rsp.ready) rvalid_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == MAXV - CNT_W'(1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               if (req.op == OP_LOAD) begin
                  if (CNT_W'(req.row_index) < MAXV) begin
                     succ_we = 1'b1;
                     lrow_in = req.row_index; lbits_in = req.row_bits;
                     cnt_in = '0; state_in = S_LREAD;
                  end
               end else begin
                  visited_in = '0; root_in = '0; cnt_in = '0;
                  back_in = 1'b0; mask_in = all & ~ROW_W'(1);
                  state_in = S_ROOT;
               end
            end
         end
         S_LREAD: state_in = S_LWRITE;   // read issued at cnt
         S_LWRITE: begin
            // rewrite column lrow of predecessor row cnt
            wr_en = 1'b1;
            wr_pred = rd_pred;
            wr_pred[lrow_ff] = lbits_ff[cnt_ff[IDX_W-1:0]];
            cnt_in = cnt_ff + CNT_W'(1);
            state_in = (cnt_ff == MAXV - CNT_W'(1)) ? S_IDLE : S_LREAD;
         end
         S_ROOT: begin
            if (cnt_ff >= live) begin
               state_in = S_BSTART;
            end else if (!visited_ff[cnt_ff[IDX_W-1:0]]) begin
               root_in = cnt_ff[IDX_W-1:0];
               visited_in = visited_ff | (ROW_W'(1) << cnt_ff[IDX_W-1:0]);
               st_we = 1'b1; st_wdata = cnt_ff[IDX_W-1:0];
               depth_in = CNT_W'(1);
               cnt_in = cnt_ff + CNT_W'(1);
               state_in = S_RD;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_BSTART: begin
            back_in = 1'b1; mask_in = all;
            visited_in = ROW_W'(1) << root_ff;
            st_we = 1'b1; st_wdata = root_ff; depth_in = CNT_W'(1);
            state_in = S_RD;
         end
         S_RD: state_in = S_WAIT;          // stack top read
         S_WAIT: begin
            rd_addr = top_ff;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (nxt != '0) begin
               visited_in = visited_ff | (ROW_W'(1) << low);
               if (depth_ff < CNT_W'(ROW_W)) begin
                  st_we = 1'b1; st_waddr = depth_ff[IDX_W-1:0]; st_wdata = low;
                  depth_in = depth_ff + CNT_W'(1);
               end
               state_in = S_RD;
            end else begin
               depth_in = depth_ff - CNT_W'(1);
               if (depth_ff == CNT_W'(1)) state_in = back_ff ? S_OUT : S_ROOT;
               else state_in = S_RD;
            end
         end
         S_OUT: begin
            if (!rvalid_ff) begin
               rvalid_in = 1'b1; rmask_in = visited_ff; rroot_in = root_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; vcount_ff <= CNT_W'(64); cnt_ff <= '0;
         visited_ff <= '0; depth_ff <= '0; root_ff <= '0; rvalid_ff <= 1'b0;
         back_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vcount_ff <= vcount_in; cnt_ff <= cnt_in;
         visited_ff <= visited_in; depth_ff <= depth_in; root_ff <= root_in;
         rvalid_ff <= rvalid_in; back_ff <= back_in;
      end
      lrow_ff <= lrow_in; lbits_ff <= lbits_in; mask_ff <= mask_in;
      rmask_ff <= rmask_in; rroot_ff <= rroot_in;
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CNT_W'(ROW_W)) else $error("stack overflow");
   a_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rvalid_ff) |-> $past(state_ff) == S_OUT) else $error("stray result");
`endif
endmodule
